// ===== sv/ddfb_pkg.sv =====
// Package for the dispenser display frame builder.
// Holds item types, pipeline sizes and the binary-to-BCD step function.
// No dependencies.
package ddfb_pkg;

   localparam int FRAME_LEN    = 16;
   localparam int SLOT_W       = $clog2(FRAME_LEN);
   localparam int DIGIT_W      = 4;
   localparam int VOL_W        = 24;
   localparam int PRICE_W      = 20;
   localparam int PROD_W       = VOL_W + PRICE_W;
   localparam int BITS_PER_STG = 8;
   localparam int DD_STAGES    = (PROD_W + BITS_PER_STG - 1) / BITS_PER_STG;
   localparam int SRC_W        = DD_STAGES * BITS_PER_STG;
   localparam int BCD_DIGITS   = 10;
   localparam int BCD_W        = BCD_DIGITS * DIGIT_W;

   typedef struct packed {
      logic [VOL_W-1:0]   volume_ml;
      logic [PRICE_W-1:0] price_cents;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   typedef logic [FRAME_LEN-1:0][DIGIT_W-1:0] frame_type;

   // Source words still to be shifted in and the BCD digits built so far.
   typedef struct packed {
      logic [SRC_W-1:0] tot_src;
      logic [SRC_W-1:0] prc_src;
      logic [SRC_W-1:0] vol_src;
      logic [BCD_W-1:0] tot_bcd;
      logic [BCD_W-1:0] prc_bcd;
      logic [BCD_W-1:0] vol_bcd;
   } dd_type;

   // One shift-add-3 step: correct every digit, then shift the new bit in.
   // Digits above the top one fall off, which leaves the low digits exact.
   function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
                                                   input logic             bit_in);
      logic [BCD_W-1:0]   fixed;
      logic [DIGIT_W-1:0] dig;
      fixed = bcd;
      for (int k = 0; k < BCD_DIGITS; k++) begin
         dig = bcd[k*DIGIT_W +: DIGIT_W];
         if (dig >= DIGIT_W'(5)) begin
            fixed[k*DIGIT_W +: DIGIT_W] = dig + DIGIT_W'(3);
         end
      end
      return {fixed[BCD_W-2:0], bit_in};
   endfunction

endpackage

// ===== sv/ddfb_pipe.sv =====
// Arithmetic pipeline of the display frame builder: product, then BCD conversion.
// Depends on ddfb_pkg. Emits one digit frame per item, held while out_take is low.
module ddfb_pipe
   import ddfb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  req_type   in_item,
   output logic      in_ready,
   output logic      out_valid,
   output frame_type out_frame,
   input  logic      out_take
);

   localparam int NSTG = DD_STAGES + 2;

   logic [NSTG-1:0]     vld_ff, vld_in;
   logic [NSTG-1:0]     adv;
   logic [NSTG-1:0]     room;
   req_type             req_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [VOL_W-1:0]    vol1_ff;
   logic [PRICE_W-1:0]  prc1_ff;
   dd_type              dd_ff [DD_STAGES];
   dd_type              dd_in [DD_STAGES];
   dd_type              dd_src [DD_STAGES];

   // Stage i moves on when it is full and the stage after has room.
   always_comb begin
      room[NSTG-1] = out_take;
      for (int i = NSTG - 1; i >= 0; i--) begin
         if (i < NSTG - 1) begin
            room[i] = !vld_ff[i+1] || adv[i+1];
         end
         adv[i] = vld_ff[i] && room[i];
      end
   end

   assign in_ready  = !vld_ff[0] || adv[0];
   assign out_valid = vld_ff[NSTG-1];

   always_comb begin
      vld_in = vld_ff;
      if (in_ready) begin
         vld_in[0] = in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
         if (!vld_ff[i] || adv[i]) begin
            vld_in[i] = adv[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Input register, then the volume-by-price product.
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         req_ff <= in_item;
      end
      if (adv[0]) begin
         prod_ff <= PROD_W'(req_ff.volume_ml) * PROD_W'(req_ff.price_cents);
         vol1_ff <= req_ff.volume_ml;
         prc1_ff <= req_ff.price_cents;
      end
   end

   // Conversion stages: eight bits of each source per stage.
   always_comb begin
      dd_src[0].tot_src = SRC_W'(prod_ff);
      dd_src[0].prc_src = SRC_W'(prc1_ff);
      dd_src[0].vol_src = SRC_W'(vol1_ff);
      dd_src[0].tot_bcd = '0;
      dd_src[0].prc_bcd = '0;
      dd_src[0].vol_bcd = '0;
      for (int g = 1; g < DD_STAGES; g++) begin
         dd_src[g] = dd_ff[g-1];
      end
      for (int g = 0; g < DD_STAGES; g++) begin
         dd_in[g] = dd_src[g];
         for (int b = 0; b < BITS_PER_STG; b++) begin
            dd_in[g].tot_bcd = dabble_bit(dd_in[g].tot_bcd, dd_in[g].tot_src[SRC_W-1]);
            dd_in[g].prc_bcd = dabble_bit(dd_in[g].prc_bcd, dd_in[g].prc_src[SRC_W-1]);
            dd_in[g].vol_bcd = dabble_bit(dd_in[g].vol_bcd, dd_in[g].vol_src[SRC_W-1]);
            dd_in[g].tot_src = {dd_in[g].tot_src[SRC_W-2:0], 1'b0};
            dd_in[g].prc_src = {dd_in[g].prc_src[SRC_W-2:0], 1'b0};
            dd_in[g].vol_src = {dd_in[g].vol_src[SRC_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < DD_STAGES; g++) begin
         if (adv[g+1]) begin
            dd_ff[g] <= dd_in[g];
         end
      end
   end

   // Lay out the frame. Total digit k is product digit k+3, so slot s of the
   // total field shows product digit s.
   always_comb begin
      for (int s = 0; s < FRAME_LEN; s++) begin
         if (s < 4) begin
            out_frame[s] = dd_ff[DD_STAGES-1].prc_bcd[(s+1)*DIGIT_W +: DIGIT_W];
         end else if (s < 10) begin
            out_frame[s] = dd_ff[DD_STAGES-1].tot_bcd[s*DIGIT_W +: DIGIT_W];
         end else begin
            out_frame[s] = dd_ff[DD_STAGES-1].vol_bcd[(s-10)*DIGIT_W +: DIGIT_W];
         end
      end
   end

endmodule

// ===== sv/dispenser_display_frame_builder_top.sv =====
// Top level of the dispenser display frame builder.
// Depends on ddfb_pkg and ddfb_pipe; holds the frame serializer.
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_item          in         taken when start & !busy
//   response  rsp_strobe, rsp_item           out        one byte per strobe cycle
//
// Each item yields sixteen bytes, slot 0 first, one per clock; an item thus
// occupies the serializer for its sixteen bytes, which sets the sustained rate. The
// arithmetic pipeline (input register, multiplier, six BCD stages) registers
// each item in that order before the serializer loads its frame, and keeps
// further items queued.
// Reset clears valid bits and the serializer; nothing needs a clearing pass.
// The receiver cannot stall; busy rises when the pipeline is full behind the
// serializer, and items in flight hold in place meanwhile.
module dispenser_display_frame_builder_top
   import ddfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   logic              in_ready;
   logic              pipe_valid;
   frame_type         pipe_frame;
   logic              load;

   logic              active_ff, active_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   frame_type         frame_ff;

   assign busy = !in_ready;

   ddfb_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_item   (req_item),
      .in_ready  (in_ready),
      .out_valid (pipe_valid),
      .out_frame (pipe_frame),
      .out_take  (load)
   );

   // Take a new frame when idle or while sending the last byte of the current one.
   assign load = pipe_valid && (!active_ff || slot_ff == SLOT_W'(FRAME_LEN - 1));

   always_comb begin
      active_in = active_ff;
      slot_in   = slot_ff;
      if (load) begin
         active_in = 1'b1;
         slot_in   = '0;
      end else if (active_ff) begin
         slot_in = slot_ff + SLOT_W'(1);
         if (slot_ff == SLOT_W'(FRAME_LEN - 1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         slot_ff   <= '0;
      end else begin
         active_ff <= active_in;
         slot_ff   <= slot_in;
      end
   end

   // Shift the frame down one digit per byte sent.
   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= pipe_frame;
      end else if (active_ff) begin
         frame_ff <= {DIGIT_W'(0), frame_ff[FRAME_LEN-1:1]};
      end
   end

   assign rsp_strobe          = active_ff;
   assign rsp_item.frame_byte = {frame_ff[0], slot_ff};
   assign rsp_item.last_byte  = (slot_ff == SLOT_W'(FRAME_LEN - 1));

endmodule

// ===== bench/tb_dispenser_display_frame_builder_top.sv =====
// Self-checking bench for the dispenser display frame builder top level.
// Depends on ddfb_pkg and dispenser_display_frame_builder_top; predicts every
// frame byte from the volume and price of each accepted item.
module tb_dispenser_display_frame_builder_top;
   import ddfb_pkg::*;

   // Longest run of cycles with neither an accepted item nor an owed frame byte.
   localparam int IDLE_LIMIT  = 1000;
   // Cycles to keep watching for stray bytes once nothing is expected.
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_ITEMS = 80;
   localparam int MAX_REPORTS = 10;

   // Frame predictor and store of the bytes still owed by the block.
   class frame_scoreboard;
      rsp_type expected_bytes[$];
      int      mismatches = 0;

      // Build the sixteen bytes one item must produce, slot 0 first.
      function void note_request(req_type item);
         logic [63:0] vol;
         logic [63:0] price;
         logic [63:0] total;
         logic [63:0] src;
         logic [3:0]  digit;
         rsp_type     byte_out;
         int          power;
         vol   = 64'(item.volume_ml);
         price = 64'(item.price_cents);
         total = (vol * price) / 64'd1000;
         for (int slot = 0; slot < FRAME_LEN; slot++) begin
            // Price shows 10^1..10^4, total 10^1..10^6, volume 10^0..10^5.
            if (slot < 4) begin
               src   = price;
               power = slot + 1;
            end else if (slot < 10) begin
               src   = total;
               power = slot - 3;
            end else begin
               src   = vol;
               power = slot - 10;
            end
            for (int k = 0; k < power; k++) begin
               src = src / 64'd10;
            end
            digit               = 4'(src % 64'd10);
            byte_out.frame_byte = {digit, 4'(slot)};
            byte_out.last_byte  = (slot == FRAME_LEN - 1);
            expected_bytes.push_back(byte_out);
         end
      endfunction

      // Compare one strobed byte against the oldest expected one.
      function void check_byte(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected byte: frame_byte=%h last_byte=%b",
                        got.frame_byte, got.last_byte);
            end
            return;
         end
         want = expected_bytes.pop_front();
         if (got.frame_byte !== want.frame_byte || got.last_byte !== want.last_byte) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("byte mismatch: frame_byte exp %h got %h, last_byte exp %b got %b",
                        want.frame_byte, got.frame_byte, want.last_byte, got.last_byte);
            end
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_item   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   frame_scoreboard frames = new();
   int              idle_cycles = 0;

   dispenser_display_frame_builder_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Check every strobed byte; the receiver never holds results off.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         frames.check_byte(rsp_item);
      end
   end

   // Abort when the handshakes stop moving for too long; stray bytes do not count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || (rsp_strobe && frames.pending() != 0)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item or byte for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Hold start low for gap cycles, then offer the item until busy drops.
   task automatic send_item(req_type item, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do begin
         @(posedge clock);
      end while (busy);
      frames.note_request(item);
   endtask

   // Drop start and wait until every owed byte has come out.
   task automatic drain_frames();
      start <= 1'b0;
      while (frames.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic req_type random_request();
      req_type item;
      int      mode;
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
         item.volume_ml   = VOL_W'($urandom_range(0, 9999999));
         item.price_cents = PRICE_W'($urandom_range(0, 999999));
      end else if (mode < 8) begin
         // Full field widths, beyond the display range.
         item.volume_ml   = VOL_W'($urandom());
         item.price_cents = PRICE_W'($urandom());
      end else begin
         // Small values keep the total near the rounding edge.
         item.volume_ml   = VOL_W'($urandom_range(0, 2000));
         item.price_cents = PRICE_W'($urandom_range(0, 2000));
      end
      return item;
   endfunction

   initial begin
      req_type directed[$];
      req_type item;
      int      gap;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero values, field extremes and display range limits.
      directed.push_back('{volume_ml: 24'd0,        price_cents: 20'd0});
      directed.push_back('{volume_ml: 24'hFFFFFF,   price_cents: 20'hFFFFF});
      directed.push_back('{volume_ml: 24'd9999999,  price_cents: 20'd999999});
      directed.push_back('{volume_ml: 24'hFFFFFF,   price_cents: 20'd0});
      directed.push_back('{volume_ml: 24'd0,        price_cents: 20'hFFFFF});
      directed.push_back('{volume_ml: 24'd1,        price_cents: 20'd1});
      // Total just below and at one unit.
      directed.push_back('{volume_ml: 24'd999,      price_cents: 20'd1});
      directed.push_back('{volume_ml: 24'd1000,     price_cents: 20'd1});
      directed.push_back('{volume_ml: 24'd1001,     price_cents: 20'd999});
      // Distinct digits in every position.
      directed.push_back('{volume_ml: 24'd123456,   price_cents: 20'd987654});
      directed.push_back('{volume_ml: 24'd654321,   price_cents: 20'd13579});
      // Dropped digits: price units digit, volume above 10^5, total above 10^6.
      directed.push_back('{volume_ml: 24'd9,        price_cents: 20'd9});
      directed.push_back('{volume_ml: 24'd10000000, price_cents: 20'd10});
      directed.push_back('{volume_ml: 24'd9999999,  price_cents: 20'd100000});
      directed.push_back('{volume_ml: 24'd1000000,  price_cents: 20'd1000});
      // Bit patterns so every input bit toggles.
      directed.push_back('{volume_ml: 24'h800000,   price_cents: 20'h80000});
      directed.push_back('{volume_ml: 24'h555555,   price_cents: 20'hAAAAA});
      directed.push_back('{volume_ml: 24'hAAAAAA,   price_cents: 20'h55555});
      directed.push_back('{volume_ml: 24'h7FFFFF,   price_cents: 20'h7FFFF});

      // Send the directed items back to back.
      foreach (directed[i]) begin
         send_item(directed[i], 0);
      end

      // Run random items: bursts with no gaps alternate with random gaps.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         item = random_request();
         if ((i / 20) % 3 == 1) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 3);
         end
         if (i == RANDOM_ITEMS / 2) begin
            drain_frames();
         end
         send_item(item, gap);
      end

      // Wait out every owed byte, then watch for strays.
      drain_frames();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (frames.mismatches == 0 && frames.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
